[rtl/core/elapsed_time_moving_average_assert.svh]
// ----------------------------------------------------------------------------
// elapsed time moving average assertion macros
// concurrent checks clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ELAPSED_TIME_MOVING_AVERAGE_ASSERT_SVH
`define ELAPSED_TIME_MOVING_AVERAGE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ETMA_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define ETMA_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[rtl/core/etma_pkg.sv]
// ----------------------------------------------------------------------------
// etma_pkg
// widths, register indexes and reset values of the elapsed time averager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etma_pkg;

  localparam int TICK_W        = 63;
  localparam int FREQ_W        = 48;
  localparam int LEN_W         = 6;
  localparam int SEC_W         = 40;
  localparam int FRACTION_BITS = 16;
  localparam int WINDOW_DEPTH  = 32;
  localparam int RING_AW       = $clog2(WINDOW_DEPTH);
  localparam int SUM_W         = SEC_W + RING_AW;
  localparam int DVD_SEC_W     = TICK_W + FRACTION_BITS;
  localparam int CNT_W         = $clog2(DVD_SEC_W);

  localparam int CFG_INDEX_W   = 4;
  localparam int CFG_DATA_W    = FREQ_W;

  localparam int IN_TDATA_W    = ((2 * TICK_W + 7) / 8) * 8;
  localparam int OUT_BITS      = 2 * SEC_W + LEN_W;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_INDEX_W-1:0] REG_TICK_FREQUENCY = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = CFG_INDEX_W'(1);

  localparam logic [FREQ_W-1:0] TICK_FREQUENCY_RESET = FREQ_W'(10000000);
  localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RESET  = LEN_W'(32);

  typedef logic [SEC_W-1:0] seconds_t;

endpackage

[rtl/core/elapsed_time_moving_average.sv]
// ----------------------------------------------------------------------------
// elapsed_time_moving_average
// tick interval to seconds conversion with a sliding window mean
// ----------------------------------------------------------------------------
// usage
//   s_tdata carries a start and an end tick count; the block converts
//   |end - start| / tick_frequency to unsigned seconds with 16 fraction
//   bits (saturated at 40 bits), pushes it into a ring of the most recent
//   window_length samples and returns sample, window mean and fill count
//   on m_tdata, one result beat per input beat
//   sequence: a beat is taken in idle, the seconds divider produces its
//   quotient one bit at a time, the update state writes ring and sum,
//   the mean divider runs bit-serially as well, then the output register
//   is loaded; the next input beat is taken only after that, so the block
//   does not accept a new beat before it is through with the last, a
//   limit set by the two bit-serial dividers
//   the ring is a 32 x 40 memory with registered read; the sample to drop
//   is read at acceptance and its slot rewritten in the update cycle
//   reset restores tick_frequency and window_length and empties the
//   window; a write of window_length empties it as well; no clearing pass
//   a stalled receiver holds the result in the output register while the
//   block goes on with the next item; it waits only if that one is done too
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elapsed_time_moving_average (
  input  logic                                clk,
  input  logic                                rst,
  // input beat
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // start_ticks [62:0], end_ticks [125:63], zero pad
  input  logic [etma_pkg::IN_TDATA_W-1:0]     s_tdata,
  // result beat
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sample_seconds [39:0], average_seconds [79:40], samples_held [85:80], zero pad
  output logic [etma_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [etma_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [etma_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TICK_W    = etma_pkg::TICK_W;
  localparam int FREQ_W    = etma_pkg::FREQ_W;
  localparam int LEN_W     = etma_pkg::LEN_W;
  localparam int SEC_W     = etma_pkg::SEC_W;
  localparam int SUM_W     = etma_pkg::SUM_W;
  localparam int RING_AW   = etma_pkg::RING_AW;
  localparam int DVD_SEC_W = etma_pkg::DVD_SEC_W;
  localparam int CNT_W     = etma_pkg::CNT_W;

  // controller states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV_SEC = 3'd1;
  localparam logic [2:0] ST_UPDATE  = 3'd2;
  localparam logic [2:0] ST_DIV_AVG = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  // configuration registers
  logic [FREQ_W-1:0]  tick_frequency;
  logic [LEN_W-1:0]   window_length;

  // window state
  logic [RING_AW-1:0] ring_position;
  logic [LEN_W-1:0]   fill_count;
  logic [SUM_W-1:0]   window_sum;

  // sample ring, registered read port
  etma_pkg::seconds_t ring [etma_pkg::WINDOW_DEPTH];
  etma_pkg::seconds_t ring_rd;

  // controller
  logic [2:0]           state;
  logic [CNT_W-1:0]     step_cnt;
  logic [RING_AW-1:0]   item_pos;
  logic                 item_drop;

  // seconds divider: dividend shifts out on top, quotient shifts in below
  logic [DVD_SEC_W-1:0] dvd_sec;
  logic [FREQ_W-1:0]    rem_sec;
  // mean divider
  logic [SUM_W-1:0]     dvd_avg;
  logic [LEN_W-1:0]     rem_avg;

  // output register
  etma_pkg::seconds_t   sample_hold;
  etma_pkg::seconds_t   out_sample;
  etma_pkg::seconds_t   out_average;
  logic [LEN_W-1:0]     out_held;

  // ---------------------------------------------------------------------------
  // item setup at acceptance
  // ---------------------------------------------------------------------------
  logic               accept;
  logic [TICK_W-1:0]  start_ticks;
  logic [TICK_W-1:0]  end_ticks;
  logic [TICK_W:0]    diff_fwd;
  logic [TICK_W-1:0]  diff_rev;
  logic [TICK_W-1:0]  diff_abs;
  logic [LEN_W-1:0]   eff_len;
  logic [RING_AW-1:0] pos_cur;
  logic [LEN_W-1:0]   pos_inc;
  logic [RING_AW-1:0] pos_next;
  logic               drop_cur;
  logic [LEN_W-1:0]   fill_next;

  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign start_ticks = s_tdata[TICK_W-1:0];
  assign end_ticks   = s_tdata[2*TICK_W-1:TICK_W];

  // borrow of end - start says which way round the interval is
  assign diff_fwd = {1'b0, end_ticks} - {1'b0, start_ticks};
  assign diff_rev = start_ticks - end_ticks;
  assign diff_abs = diff_fwd[TICK_W] ? diff_rev : diff_fwd[TICK_W-1:0];

  // zero length acts as one, anything past the ring depth is clamped
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (window_length > LEN_W'(etma_pkg::WINDOW_DEPTH)) begin
      eff_len = LEN_W'(etma_pkg::WINDOW_DEPTH);
    end else begin
      eff_len = window_length;
    end
  end

  // a shrunk window may leave the write pointer past its end
  assign pos_cur   = ({1'b0, ring_position} >= eff_len) ? '0 : ring_position;
  assign pos_inc   = {1'b0, pos_cur} + LEN_W'(1);
  assign pos_next  = (pos_inc >= eff_len) ? '0 : pos_inc[RING_AW-1:0];
  assign drop_cur  = (fill_count >= eff_len);
  assign fill_next = drop_cur ? eff_len : fill_count + LEN_W'(1);

  // ---------------------------------------------------------------------------
  // divider steps
  // ---------------------------------------------------------------------------
  logic [FREQ_W:0]    rem_sec_sh;
  logic [FREQ_W:0]    rem_sec_sub;
  logic               sec_bit;
  logic [LEN_W:0]     rem_avg_sh;
  logic [LEN_W:0]     rem_avg_sub;
  logic               avg_bit;
  etma_pkg::seconds_t sample_sec;
  logic [SUM_W-1:0]   drop_val;
  logic [SUM_W-1:0]   sum_next;

  assign rem_sec_sh  = {rem_sec, dvd_sec[DVD_SEC_W-1]};
  assign rem_sec_sub = rem_sec_sh - {1'b0, tick_frequency};
  assign sec_bit     = (rem_sec_sh >= {1'b0, tick_frequency});

  assign rem_avg_sh  = {rem_avg, dvd_avg[SUM_W-1]};
  assign rem_avg_sub = rem_avg_sh - {1'b0, fill_count};
  assign avg_bit     = (rem_avg_sh >= {1'b0, fill_count});

  // any quotient bit above the field saturates; a zero frequency sets them all
  assign sample_sec = (|dvd_sec[DVD_SEC_W-1:SEC_W]) ? '1 : dvd_sec[SEC_W-1:0];

  assign drop_val = item_drop ? SUM_W'(ring_rd) : '0;
  assign sum_next = window_sum - drop_val + SUM_W'(sample_sec);

  // ---------------------------------------------------------------------------
  // sample ring
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      ring[item_pos] <= sample_sec;
    end
    if (accept) begin
      ring_rd <= ring[pos_cur];
    end
  end

  // ---------------------------------------------------------------------------
  // configuration, window state and controller
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_frequency <= etma_pkg::TICK_FREQUENCY_RESET;
      window_length  <= etma_pkg::WINDOW_LENGTH_RESET;
      ring_position  <= '0;
      fill_count     <= '0;
      window_sum     <= '0;
      state          <= ST_IDLE;
      step_cnt       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // in the done state the next result takes over the register instead
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          etma_pkg::REG_TICK_FREQUENCY: begin
            tick_frequency <= cfg_data[FREQ_W-1:0];
          end
          etma_pkg::REG_WINDOW_LENGTH: begin
            window_length <= cfg_data[LEN_W-1:0];
            ring_position <= '0;
            fill_count    <= '0;
            window_sum    <= '0;
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ring_position <= pos_next;
            fill_count    <= fill_next;
            step_cnt      <= CNT_W'(DVD_SEC_W - 1);
            state         <= ST_DIV_SEC;
          end
        end
        ST_DIV_SEC: begin
          step_cnt <= step_cnt - CNT_W'(1);
          if (step_cnt == '0) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          window_sum <= sum_next;
          step_cnt   <= CNT_W'(SUM_W - 1);
          state      <= ST_DIV_AVG;
        end
        ST_DIV_AVG: begin
          step_cnt <= step_cnt - CNT_W'(1);
          if (step_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait here only while the previous result is still unclaimed
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          dvd_sec   <= {diff_abs, etma_pkg::FRACTION_BITS'(0)};
          rem_sec   <= '0;
          item_pos  <= pos_cur;
          item_drop <= drop_cur;
        end
      end
      ST_DIV_SEC: begin
        rem_sec <= sec_bit ? rem_sec_sub[FREQ_W-1:0] : rem_sec_sh[FREQ_W-1:0];
        dvd_sec <= {dvd_sec[DVD_SEC_W-2:0], sec_bit};
      end
      ST_UPDATE: begin
        sample_hold <= sample_sec;
        dvd_avg     <= sum_next;
        rem_avg     <= '0;
      end
      ST_DIV_AVG: begin
        rem_avg <= avg_bit ? rem_avg_sub[LEN_W-1:0] : rem_avg_sh[LEN_W-1:0];
        dvd_avg <= {dvd_avg[SUM_W-2:0], avg_bit};
      end
      ST_DONE: begin
        if (out_free) begin
          out_sample  <= sample_hold;
          // the mean never exceeds the largest sample, so it fits 40 bits
          out_average <= dvd_avg[SEC_W-1:0];
          out_held    <= fill_count;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {{(etma_pkg::OUT_TDATA_W - etma_pkg::OUT_BITS){1'b0}},
                    out_held, out_average, out_sample};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `include "elapsed_time_moving_average_assert.svh"

  `ETMA_ASSERT_NEXT(a_accept_starts_div, accept, state == ST_DIV_SEC, "accept did not start the divider")
  `ETMA_ASSERT_NEXT(a_div_sec_ends, (state == ST_DIV_SEC) && (step_cnt == '0), state == ST_UPDATE, "seconds divider overran")
  `ETMA_ASSERT_NOW(a_fill_nonzero, state == ST_UPDATE, (fill_count != '0) && (fill_count <= LEN_W'(etma_pkg::WINDOW_DEPTH)), "fill count out of range in update")
  `ETMA_ASSERT_NOW(a_held_nonzero, m_tvalid, m_tdata[etma_pkg::OUT_BITS-1:2*SEC_W] != '0, "result with an empty window")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives tick interval beats and register writes into the elapsed time
// averager and checks every result beat against a cycle-free predictor of
// the seconds conversion and the sliding window mean
// ----------------------------------------------------------------------------

module tb;

  localparam int TICK_W        = etma_pkg::TICK_W;
  localparam int FREQ_W        = etma_pkg::FREQ_W;
  localparam int LEN_W         = etma_pkg::LEN_W;
  localparam int SUM_W         = etma_pkg::SUM_W;
  localparam int DVD_SEC_W     = etma_pkg::DVD_SEC_W;
  localparam int FRACTION_BITS = etma_pkg::FRACTION_BITS;
  localparam int WINDOW_DEPTH  = etma_pkg::WINDOW_DEPTH;
  localparam int CFG_INDEX_W   = etma_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W    = etma_pkg::CFG_DATA_W;
  localparam int IN_TDATA_W    = etma_pkg::IN_TDATA_W;
  localparam int OUT_BITS      = etma_pkg::OUT_BITS;
  localparam int OUT_TDATA_W   = etma_pkg::OUT_TDATA_W;

  localparam logic [CFG_INDEX_W-1:0] REG_TICK_FREQUENCY = etma_pkg::REG_TICK_FREQUENCY;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = etma_pkg::REG_WINDOW_LENGTH;
  localparam logic [FREQ_W-1:0] TICK_FREQUENCY_RESET = etma_pkg::TICK_FREQUENCY_RESET;
  localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RESET  = etma_pkg::WINDOW_LENGTH_RESET;

  typedef etma_pkg::seconds_t seconds_t;

  localparam int HOLD_CYCLES  = 1500;
  localparam int RANDOM_ITEMS = 1630;
  localparam int SETTLE       = 300;
  localparam int PRINT_LIMIT  = 40;

  localparam logic [TICK_W-1:0]      TICK_MAX         = '1;
  localparam seconds_t               SEC_FULL         = '1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_WINDOW_LENGTH + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = '1;

  // same bit order as m_tdata: sample lowest, fill count highest
  typedef struct packed {
    logic [LEN_W-1:0] held;
    seconds_t         mean_sec;
    seconds_t         sample_sec;
  } result_t;

  // one row of the directed table: a register write or an input beat
  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [TICK_W-1:0]      t0;
    logic [TICK_W-1:0]      t1;
    bit                     known;
    result_t                res;
  } step_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tready  = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // predictor copy of the registers and the window
  logic [FREQ_W-1:0] hz_now   = TICK_FREQUENCY_RESET;
  logic [LEN_W-1:0]  len_now  = WINDOW_LENGTH_RESET;
  seconds_t          window_mem [WINDOW_DEPTH];
  int                slot_next = 0;
  int                fill_now  = 0;
  logic [SUM_W-1:0]  sum_now   = '0;

  result_t pending_results [$];
  int      mismatches = 0;
  bit      hold_req   = 1'b0;

  elapsed_time_moving_average DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // floor(span * 2^16 / hz), saturated; zero hz saturates as well
  function automatic seconds_t interval_seconds(logic [TICK_W-1:0] span,
                                                logic [FREQ_W-1:0] hz);
    logic [DVD_SEC_W-1:0] q;
    if (hz == '0) return SEC_FULL;
    q = {span, FRACTION_BITS'(0)} / DVD_SEC_W'(hz);
    if (q > DVD_SEC_W'(SEC_FULL)) return SEC_FULL;
    return q[SEC_W_LOW-1:0];
  endfunction

  localparam int SEC_W_LOW = $bits(seconds_t);

  // push one sample into the window and return the expected result beat
  function automatic result_t window_after(logic [TICK_W-1:0] t0, logic [TICK_W-1:0] t1);
    logic [TICK_W-1:0] span;
    int                len;
    int                pos;
    result_t           r;
    span = (t1 >= t0) ? t1 - t0 : t0 - t1;
    r.sample_sec = interval_seconds(span, hz_now);
    // zero length means one sample, anything past the ring depth is clamped
    len = int'(len_now);
    if (len == 0) len = 1;
    if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
    pos = slot_next;
    if (pos >= len) pos = 0;
    if (fill_now >= len) begin
      sum_now -= SUM_W'(window_mem[pos]);
      fill_now = len;
    end else begin
      fill_now++;
    end
    window_mem[pos] = r.sample_sec;
    sum_now += SUM_W'(r.sample_sec);
    pos++;
    if (pos >= len) pos = 0;
    slot_next = pos;
    r.mean_sec = seconds_t'(sum_now / SUM_W'(fill_now));
    r.held = LEN_W'(fill_now);
    return r;
  endfunction

  function automatic step_t item_step(logic [TICK_W-1:0] t0, logic [TICK_W-1:0] t1);
    step_t s;
    s.is_cfg = 1'b0;
    s.idx    = '0;
    s.val    = '0;
    s.t0     = t0;
    s.t1     = t1;
    s.known  = 1'b0;
    s.res    = '0;
    return s;
  endfunction

  function automatic step_t known_step(logic [TICK_W-1:0] t0, logic [TICK_W-1:0] t1,
                                       seconds_t smp, seconds_t avg, logic [LEN_W-1:0] n);
    step_t s;
    s = item_step(t0, t1);
    s.known = 1'b1;
    s.res.sample_sec = smp;
    s.res.mean_sec = avg;
    s.res.held = n;
    return s;
  endfunction

  function automatic step_t cfg_step(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = item_step('0, '0);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  // mostly back to back or short, now and then a long pause
  function automatic int pause_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 31);
    if (r == 0) return $urandom_range(100, 400);
    if (r < 4) return $urandom_range(10, 60);
    if (r < 16) return 0;
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_freq();
    case ($urandom_range(0, 5))
      0:       return FREQ_W'($urandom_range(1, 1000));
      1:       return '1;
      2:       return FREQ_W'(1) << $urandom_range(0, FREQ_W - 1);
      3:       return TICK_FREQUENCY_RESET;
      4:       return FREQ_W'($urandom);
      default: return FREQ_W'({$urandom, $urandom});
    endcase
  endfunction

  // upper data bits are don't-care for the length register, so fill them at times
  function automatic logic [CFG_DATA_W-1:0] pick_len();
    logic [CFG_DATA_W-1:0] v;
    v = $urandom_range(0, 1) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
    case ($urandom_range(0, 7))
      0:       v[LEN_W-1:0] = '0;
      1:       v[LEN_W-1:0] = LEN_W'($urandom_range(33, 63));
      2, 3:    v[LEN_W-1:0] = LEN_W'(WINDOW_DEPTH);
      4, 5:    v[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
      default: v[LEN_W-1:0] = LEN_W'($urandom_range(1, WINDOW_DEPTH));
    endcase
    return v;
  endfunction

  task automatic report(string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, what);
  endtask

  // valid stays high on return so a back to back beat can follow without dropping it
  task automatic offer_item(input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1,
                            input bit known, input result_t res);
    result_t want;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({t1, t0});
    do @(posedge clk); while (!s_tready);
    want = window_after(t0, t1);
    pending_results = {pending_results, (known ? res : want)};
  endtask

  task automatic rest(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering and wait until every outstanding result beat is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_TICK_FREQUENCY) begin
      hz_now = val[FREQ_W-1:0];
    end else if (idx == REG_WINDOW_LENGTH) begin
      // a length write empties the window
      len_now   = val[LEN_W-1:0];
      slot_next = 0;
      fill_now  = 0;
      sum_now   = '0;
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random ready with short and long gaps, one long hold-off on request
  initial begin : result_sink
    int run;
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pause_len(1'b0);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[OUT_BITS-1:0]);
      if (pending_results.size() == 0) begin
        report($sformatf("result beat %h with nothing outstanding", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.sample_sec !== want.sample_sec)
          report($sformatf("sample_seconds %h, wanted %h", got.sample_sec, want.sample_sec));
        if (got.mean_sec !== want.mean_sec)
          report($sformatf("average_seconds %h, wanted %h", got.mean_sec, want.mean_sec));
        if (got.held !== want.held)
          report($sformatf("samples_held %0d, wanted %0d", got.held, want.held));
      end
    end
  end

  initial begin : stimulus
    step_t             plan [$];
    logic [TICK_W-1:0] t0;
    logic [TICK_W-1:0] t1;
    int                phase;
    int                n;
    int                random_items;
    bit                quiet;

    // reset values: 10 MHz ticks, full window
    plan = {plan, known_step(0, 0, 0, 0, 1)};
    plan = {plan, known_step(0, 10_000_000, 65536, 32768, 2)};
    // start after end gives the absolute difference
    plan = {plan, known_step(30_000_000, 10_000_000, 131072, 65536, 3)};
    plan = {plan, item_step(0, TICK_MAX)};
    plan = {plan, item_step(TICK_MAX, 0)};
    plan = {plan, item_step(TICK_MAX, TICK_MAX)};
    plan = {plan, item_step(5, 15_000_005)};
    // zero frequency saturates, window of one
    plan = {plan, cfg_step(REG_WINDOW_LENGTH, 1)};
    plan = {plan, cfg_step(REG_TICK_FREQUENCY, 0)};
    plan = {plan, known_step(5, 3, SEC_FULL, SEC_FULL, 1)};
    plan = {plan, known_step(0, 0, SEC_FULL, SEC_FULL, 1)};
    // largest frequency, zero length acts as one
    plan = {plan, cfg_step(REG_TICK_FREQUENCY, '1)};
    plan = {plan, cfg_step(REG_WINDOW_LENGTH, 0)};
    plan = {plan, item_step(0, TICK_MAX)};
    plan = {plan, known_step(0, 1, 0, 0, 1)};
    // one tick per second: largest unsaturated value, then overflow; length clamped
    plan = {plan, cfg_step(REG_TICK_FREQUENCY, 1)};
    plan = {plan, cfg_step(REG_WINDOW_LENGTH, 63)};
    plan = {plan, known_step(0, 63'hFF_FFFF, 40'hFF_FFFF_0000, 40'hFF_FFFF_0000, 1)};
    plan = {plan, item_step(63'h100_0000, 0)};
    plan = {plan, item_step(TICK_MAX, TICK_MAX - 1)};
    // writes to unused indexes change nothing
    plan = {plan, cfg_step(REG_FIRST_UNUSED, 0)};
    plan = {plan, cfg_step(REG_LAST_UNUSED, '1)};
    plan = {plan, item_step(0, 3)};
    plan = {plan, cfg_step(REG_TICK_FREQUENCY, 3)};
    plan = {plan, item_step(0, 1)};
    // two sample window wraps; junk above the length field is dropped
    plan = {plan, cfg_step(REG_WINDOW_LENGTH, 48'hABCD_EF12_3402)};
    plan = {plan, known_step(0, 3, 65536, 65536, 1)};
    plan = {plan, known_step(0, 6, 131072, 98304, 2)};
    plan = {plan, known_step(0, 9, 196608, 163840, 2)};

    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        offer_item(plan[i].t0, plan[i].t1, plan[i].known, plan[i].res);
        rest(pause_len(1'b0));
      end
    end

    // random phases, each under its own register setting; the first few pin the extremes
    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_TICK_FREQUENCY, TICK_FREQUENCY_RESET);
          write_reg(REG_WINDOW_LENGTH, WINDOW_DEPTH);
        end
        1: begin
          write_reg(REG_TICK_FREQUENCY, 1);
          write_reg(REG_WINDOW_LENGTH, 1);
        end
        2: begin
          write_reg(REG_TICK_FREQUENCY, '1);
          write_reg(REG_WINDOW_LENGTH, 63);
        end
        3: begin
          write_reg(REG_TICK_FREQUENCY, 0);
          write_reg(REG_WINDOW_LENGTH, 0);
        end
        4: begin
          write_reg(REG_TICK_FREQUENCY, 1000);
          write_reg(REG_WINDOW_LENGTH, 33);
        end
        default: begin
          if ($urandom_range(0, 7) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      CFG_DATA_W'({$urandom, $urandom}));
          write_reg(REG_TICK_FREQUENCY, pick_freq());
          // now and then keep the window across a frequency change
          if ($urandom_range(0, 3) != 0) write_reg(REG_WINDOW_LENGTH, pick_len());
        end
      endcase
      // one phase runs against a long receiver hold-off with the input kept busy
      quiet = (phase % 4 == 2) || (phase == 4);
      n = (phase == 4) ? 80 : $urandom_range(20, 110);
      if (phase == 4) hold_req = 1'b1;
      repeat (n) begin
        t0 = TICK_W'({$urandom, $urandom});
        // flip a random number of low bits, so the interval spans all magnitudes
        t1 = t0 ^ (TICK_W'({$urandom, $urandom}) >> $urandom_range(0, TICK_W));
        offer_item(t0, t1, 1'b0, '0);
        rest(pause_len(quiet));
      end
      random_items += n;
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
